// File: hw/rtl/sha1_message_digest_defines.svh
// Assertion macros for the SHA-1 digest block checker.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define SMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when ante holds, cons must hold in the next cycle.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/smd_pkg.sv
package smd_pkg;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_FIT    = 6'd55;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        failed;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_END, ST_SPAD, ST_FPAD, ST_LEN,
    ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT, ST_FAIL
  } state_t;

  typedef enum logic [1:0] {PH_MID, PH_SPLIT, PH_FINAL} phase_t;

  typedef struct packed {
    logic byte_we;
    logic pad;
    logic pad_fips;
    logic len;
    logic len_clr;
    logic load;
    logic round;
    logic add;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic fips;
    logic full;
    logic fill_hi;
    logic too_long;
    logic rnd_last;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// File: hw/rtl/sha1_message_digest.sv
// SHA-1 digest engine fed one message byte per transaction, the final byte
// flagged by last_byte. In standard mode every 64th byte starts
// a block compression (schedule load, 80 rounds at one round per
// cycle through a single round unit, chain update) during which
// in_stall is high. After the final byte the engine
// pads and runs one or two more compressions, then presents
// the five digest words H0..H4 as five transactions, last_word on H4, and
// returns to its initial chain and zero count. hash_mode = 1 selects FIPS 186
// single-block mode: only the first 64 bytes are kept, zero padded with no
// length word; past 1048575 bytes the message ends in a single transaction
// with failed set. hash_mode is written through cfg_we/cfg_data and is
// sampled with each byte; no input is taken while a digest is being sent.
module sha1_message_digest import smd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  word_sel;
  logic [31:0] chain_word;
  logic        out_fail;

  smd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_fail  (out_fail),
    .word_sel  (word_sel),
    .cmd       (cmd)
  );

  smd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_byte    (in_data.data_byte),
    .cmd        (cmd),
    .word_sel   (word_sel),
    .stat       (stat),
    .chain_word (chain_word)
  );

  // failure transaction carries zero word and index 0
  always_comb begin
    out_data.digest_word = out_fail ? 32'd0 : chain_word;
    out_data.word_index  = out_fail ? 3'd0 : word_sel;
    out_data.last_word   = out_fail || (word_sel == LAST_IDX);
    out_data.failed      = out_fail;
  end

endmodule

// File: hw/rtl/smd_datapath.sv
module smd_datapath import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  input  logic [2:0]  word_sel,
  output dp_stat_t    stat,
  output logic [31:0] chain_word
);

  logic        mode_r;
  logic [31:0] count_r, count_nxt;
  logic [31:0] blk_r [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] sch_r [16];
  logic [31:0] chain_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic [5:0]  pos;
  logic [4:0]  sh;
  logic        in_low;
  logic [7:0]  pbyte;
  logic [31:0] t;
  logic [31:0] w_new;

  assign pos    = count_r[5:0];
  assign sh     = {~pos[1:0], 3'b000};
  assign in_low = (count_r[31:6] == 26'd0);
  assign pbyte  = cmd.pad_fips ? 8'h00 : PAD_BYTE;

  assign stat.fips     = mode_r;
  assign stat.full     = !mode_r && (pos == 6'd63);
  assign stat.fill_hi  = (pos > LEN_FIT);
  assign stat.too_long = (count_r[31:20] != 12'd0);
  assign stat.rnd_last = (rnd_r == LAST_ROUND);

  assign chain_word = chain_r[word_sel];

  // byte placement, end padding and length words
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      blk_nxt[k] = blk_r[k];
      if (cmd.byte_we && (!mode_r || in_low) && (4'(k) == pos[5:2])) begin
        blk_nxt[k] = (pos[1:0] == 2'd0) ? {in_byte, 24'd0}
                                         : blk_r[k] | ({24'd0, in_byte} << sh);
      end
      if (cmd.pad && (!cmd.pad_fips || in_low)) begin
        if (4'(k) == pos[5:2]) begin
          blk_nxt[k] = (pos[1:0] == 2'd0) ? {pbyte, 24'd0}
                                           : blk_r[k] | ({24'd0, pbyte} << sh);
        end else if (4'(k) > pos[5:2]) begin
          blk_nxt[k] = 32'd0;
        end
      end
      if (cmd.len) begin
        if (cmd.len_clr || k == 14) blk_nxt[k] = 32'd0;
        if (k == 15) blk_nxt[k] = {count_r[28:0], 3'b000};
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.restart) count_nxt = 32'd0;
    else if (cmd.byte_we && (!mode_r || count_r != 32'hffffffff)) count_nxt = count_r + 32'd1;
  end

  assign t = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
             + sch_r[0] + round_k(rnd_r);
  assign w_new = sch_r[13] ^ sch_r[8] ^ sch_r[2] ^ sch_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= 32'd0;
      for (int i = 0; i < 5; i++) chain_r[i] <= H_INIT[i];
    end else begin
      if (cfg_we) mode_r <= cfg_data;
      count_r <= count_nxt;
      if (cmd.restart) begin
        for (int i = 0; i < 5; i++) chain_r[i] <= H_INIT[i];
      end else if (cmd.add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 16; k++) blk_r[k] <= blk_nxt[k];
    if (cmd.load) begin
      for (int k = 0; k < 16; k++) sch_r[k] <= blk_r[k];
      a_r   <= chain_r[0];
      b_r   <= chain_r[1];
      c_r   <= chain_r[2];
      d_r   <= chain_r[3];
      e_r   <= chain_r[4];
      rnd_r <= 7'd0;
    end else if (cmd.round) begin
      for (int k = 0; k < 15; k++) sch_r[k] <= sch_r[k + 1];
      sch_r[15] <= {w_new[30:0], w_new[31]};
      e_r   <= d_r;
      d_r   <= c_r;
      c_r   <= {b_r[1:0], b_r[31:2]};
      b_r   <= a_r;
      a_r   <= t;
      rnd_r <= rnd_r + 7'd1;
    end
  end

endmodule

// File: hw/rtl/smd_ctrl.sv
module smd_ctrl import smd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output logic       in_stall,
  output logic       out_valid,
  output logic       out_fail,
  output logic [2:0] word_sel,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       last_r, last_nxt;
  logic       fips_r, fips_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    last_nxt  = last_r;
    fips_nxt  = fips_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last;
          fips_nxt = stat.fips;
          phase_nxt = PH_MID;
          if (stat.full) state_nxt = ST_LOAD;
          else if (in_last) state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (!fips_r) state_nxt = ST_SPAD;
        else if (stat.too_long) state_nxt = ST_FAIL;
        else state_nxt = ST_FPAD;
      end
      ST_SPAD: begin
        if (stat.fill_hi) begin
          phase_nxt = PH_SPLIT;
          state_nxt = ST_LOAD;
        end else begin
          phase_nxt = PH_FINAL;
          state_nxt = ST_LEN;
        end
      end
      ST_FPAD: begin
        phase_nxt = PH_FINAL;
        state_nxt = ST_LOAD;
      end
      ST_LEN: begin
        phase_nxt = PH_FINAL;
        state_nxt = ST_LOAD;
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (stat.rnd_last) state_nxt = ST_ADD;
      ST_ADD: begin
        unique case (phase_r)
          PH_MID:   state_nxt = last_r ? ST_END : ST_IDLE;
          PH_SPLIT: state_nxt = ST_LEN;
          PH_FINAL: begin
            idx_nxt   = 3'd0;
            state_nxt = ST_EMIT;
          end
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      ST_FAIL: if (out_acc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    out_fail  = 1'b0;
    word_sel  = idx_r;
    cmd.pad_fips = fips_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.byte_we = in_valid;
      end
      ST_SPAD, ST_FPAD: cmd.pad = 1'b1;
      ST_LEN: begin
        cmd.len     = 1'b1;
        cmd.len_clr = (phase_r == PH_SPLIT);
      end
      ST_LOAD:  cmd.load  = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_ADD:   cmd.add   = 1'b1;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.restart = out_acc && (idx_r == LAST_IDX);
      end
      ST_FAIL: begin
        out_valid   = 1'b1;
        out_fail    = 1'b1;
        cmd.restart = out_acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MID;
      last_r  <= 1'b0;
      fips_r  <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      fips_r  <= fips_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: hw/rtl/smd_checker.sv
`include "sha1_message_digest_defines.svh"

module smd_checker import smd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `SMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `SMD_ASSERT(a_no_in_while_out, out_valid |-> in_stall, "input taken while digest pending")
  `SMD_ASSERT(a_fail_shape, (out_valid && out_data.failed) |-> (out_data.last_word && out_data.word_index == 3'd0 && out_data.digest_word == 32'd0), "bad failure result")
  `SMD_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_data.last_word, out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1), "digest word skipped")

endmodule

bind sha1_message_digest smd_checker u_smd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/tb_top.sv
module tb_top;
  import smd_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  sha1_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // FIPS 186 mode length ceiling, in bytes
  localparam logic [31:0] FIPS_MAX_BYTES = 32'h000fffff;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Digest predictor state: the testbench's own copy of the engine's state.
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  logic [31:0] msg_bytes;
  logic        mode_fips;

  out_t digest_q [$];
  int   fail_cnt;
  int   out_wait;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic chain_restart();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    msg_bytes = '0;
  endtask

  task automatic blk_put(input logic [31:0] pos, input logic [7:0] v);
    logic [5:0] sh;
    sh = 6'((3 - pos[1:0]) * 8);
    if (pos[1:0] == 2'd0) blk_w[pos[5:2]] = {24'd0, v} << sh;
    else blk_w[pos[5:2]] |= {24'd0, v} << sh;
  endtask

  // One 80-round SHA-1 compression of blk_w into chain_h.
  task automatic sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5a827999; end
      else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ed9eba1; end
      else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc; end
      else begin f = b ^ c ^ d; k = 32'hca62c1d6; end
      t = rol(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  // Advance the predictor by one accepted byte; queue any digest words.
  task automatic digest_predict(input in_t item);
    logic [31:0] pos;
    out_t r;
    if (mode_fips) begin
      if (msg_bytes < 64) blk_put(msg_bytes, item.data_byte);
      if (msg_bytes != 32'hffffffff) msg_bytes++;
    end else begin
      pos = msg_bytes & 63;
      blk_put(pos, item.data_byte);
      msg_bytes++;
      if (pos == 63) sha1_compress();
    end
    if (!item.last_byte) return;
    if (mode_fips) begin
      if (msg_bytes > FIPS_MAX_BYTES) begin
        r = '0;
        r.last_word = 1'b1;
        r.failed = 1'b1;
        digest_q.push_back(r);
        chain_restart();
        return;
      end
      for (pos = msg_bytes; pos < 64; pos++) blk_put(pos, 8'h00);
      sha1_compress();
    end else begin
      pos = msg_bytes & 63;
      blk_put(pos, PAD_BYTE);
      for (logic [31:0] p = pos + 1; p < 64; p++) blk_put(p, 8'h00);
      if (pos > 55) begin
        sha1_compress();
        for (int i = 0; i < 16; i++) blk_w[i] = '0;
      end
      blk_w[14] = '0;
      blk_w[15] = msg_bytes << 3;
      sha1_compress();
    end
    for (int i = 0; i < 5; i++) begin
      r.digest_word = chain_h[i];
      r.word_index = 3'(i);
      r.last_word = (i == 4);
      r.failed = 1'b0;
      digest_q.push_back(r);
    end
    chain_restart();
  endtask

  // Sender: random gap, then hold the transaction until accepted.
  // Valid stays high across a zero gap; set_mode drops it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_t item;
    int gap;
    item.data_byte = b;
    item.last_byte = lst;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    // in_stall is settled mid-cycle; the next rising edge takes the byte
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    digest_predict(item);
  endtask

  task automatic send_msg(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  // Mode change only when the engine is quiet.
  task automatic set_mode(input logic m);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (digest_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_fips = m;
  endtask

  // Result stall: a random wait drawn for each transaction.
  always @(posedge clk) begin
    int nw;
    nw = $urandom_range(0, 11);
    if (!rst_n || (out_valid && !out_stall)) begin
      out_wait  <= nw;
      out_stall <= (nw != 0);
    end else if (out_valid && out_stall) begin
      out_wait  <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, out_data);
        fail_cnt++;
      end else begin
        exp_r = digest_q.pop_front();
        if (out_data.digest_word !== exp_r.digest_word) begin
          $display("%0t: digest_word exp %h act %h", $time, exp_r.digest_word,
                   out_data.digest_word);
          fail_cnt++;
        end
        if (out_data.word_index !== exp_r.word_index) begin
          $display("%0t: word_index exp %0d act %0d", $time, exp_r.word_index,
                   out_data.word_index);
          fail_cnt++;
        end
        if (out_data.last_word !== exp_r.last_word) begin
          $display("%0t: last_word exp %b act %b", $time, exp_r.last_word,
                   out_data.last_word);
          fail_cnt++;
        end
        if (out_data.failed !== exp_r.failed) begin
          $display("%0t: failed exp %b act %b", $time, exp_r.failed, out_data.failed);
          fail_cnt++;
        end
      end
    end
  end

  // Directed: one-byte messages at byte extremes, block-boundary lengths.
  task automatic test_standard_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_msg(55);
    send_msg(56);
    send_msg(64);
  endtask

  // FIPS mode: short, exactly 64 and past 64 bytes.
  task automatic test_fips_directed();
    set_mode(1'b1);
    send_msg(1);
    send_msg(64);
    send_msg(66);
    set_mode(1'b0);
  endtask

  // Mode switched mid-message: a standard block then a FIPS end.
  task automatic test_mode_mix();
    for (int i = 0; i < 64; i++) send_byte(8'($urandom), 1'b0);
    set_mode(1'b1);
    send_msg(5);
    set_mode(1'b0);
  endtask

  // Random short messages in both modes.
  task automatic test_random();
    int len;
    for (int n = 0; n < 4; n++) begin
      if (n == 2) set_mode(~mode_fips);
      len = $urandom_range(1, 12);
      send_msg(len);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fail_cnt = 0;
    mode_fips = 1'b0;
    chain_restart();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_standard_directed();
    test_fips_directed();
    test_mode_mix();
    test_random();
    set_mode(1'b0);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && digest_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Watchdog: reports failure and stops a run that has not finished in time.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
